// ===== design/ssg_pkg.sv =====
// Shared types and constants for the scheduled source gate.
`default_nettype none
package ssg_pkg;

  localparam int FRAME_W    = 48;
  localparam int COUNT_W    = 13;
  localparam int CMD_W      = 2;
  localparam int STATE_W    = 3;
  localparam logic [COUNT_W-1:0] MAX_QUANTUM = 13'd4096;

  localparam int S_TDATA_W = 112;
  localparam int M_TDATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_START   = 2'd0,
    CMD_STOP    = 2'd1,
    CMD_QUANTUM = 2'd2
  } cmd_t;

  typedef enum logic [STATE_W-1:0] {
    MODE_UNSCHEDULED    = 3'd0,
    MODE_SCHEDULED      = 3'd1,
    MODE_PLAYING        = 3'd2,
    MODE_STOP_SCHEDULED = 3'd3,
    MODE_FINISHED       = 3'd4
  } mode_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [FRAME_W-1:0] frame_value;
    logic [FRAME_W-1:0] first_frame;
    logic [COUNT_W-1:0] frames_count;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] start_offset;
    logic [COUNT_W-1:0] active_count;
    logic               ended;
    mode_t              play_state;
  } res_t;

  typedef struct packed {
    mode_t              mode;
    logic [FRAME_W-1:0] start_at;
    logic [FRAME_W-1:0] stop_at;
    logic               stop_valid;
  } gate_state_t;

endpackage
`default_nettype wire

// ===== design/ssg_core.sv =====
// Per-item gate decision: next play state and result from one transfer.
`default_nettype none
module ssg_core (
  input  ssg_pkg::item_t       item,
  input  ssg_pkg::gate_state_t cur,
  input  logic                 notify,
  output ssg_pkg::gate_state_t nxt,
  output ssg_pkg::res_t        res
);
  import ssg_pkg::*;

  logic [COUNT_W-1:0] n;
  logic [FRAME_W:0]   first_x;
  logic [FRAME_W:0]   last_x;
  logic [FRAME_W:0]   stop_x;
  logic [FRAME_W:0]   start_x;
  logic [FRAME_W:0]   startf;
  logic [FRAME_W+1:0] lim;
  logic [FRAME_W+1:0] span;
  logic               stop_le_last;
  logic               stop_in;
  logic               stop_lt;
  logic [FRAME_W:0]   stop_off;

  always_comb begin
    if (item.frames_count == '0) begin
      n = COUNT_W'(1);
    end else if (item.frames_count > MAX_QUANTUM) begin
      n = MAX_QUANTUM;
    end else begin
      n = item.frames_count;
    end
    first_x      = {1'b0, item.first_frame};
    last_x       = first_x + {{(FRAME_W+1-COUNT_W){1'b0}}, n} - (FRAME_W+1)'(1);
    stop_x       = {1'b0, cur.stop_at};
    start_x      = {1'b0, cur.start_at};
    stop_le_last = cur.stop_valid && (stop_x <= last_x);
    stop_in      = stop_le_last && (stop_x >= first_x);
    stop_lt      = cur.stop_valid && (stop_x < first_x);
    stop_off     = stop_x - first_x;
    startf       = (start_x > first_x) ? start_x : first_x;
    lim          = stop_le_last ? ({1'b0, stop_x} + (FRAME_W+2)'(1))
                                : ({1'b0, last_x} + (FRAME_W+2)'(1));
    span         = (lim > {1'b0, startf}) ? (lim - {1'b0, startf}) : '0;

    nxt              = cur;
    res.start_offset = '0;
    res.active_count = '0;
    res.ended        = 1'b0;

    case (item.cmd)
      CMD_START: begin
        nxt.mode     = MODE_SCHEDULED;
        nxt.start_at = item.frame_value;
      end
      CMD_STOP: begin
        nxt.stop_at    = item.frame_value;
        nxt.stop_valid = 1'b1;
      end
      CMD_QUANTUM: begin
        unique case (cur.mode)
          MODE_SCHEDULED: begin
            if (startf <= last_x) begin
              nxt.mode         = stop_in ? MODE_STOP_SCHEDULED : MODE_PLAYING;
              res.start_offset = COUNT_W'(startf - first_x);
              res.active_count = span[COUNT_W-1:0];
            end
          end
          MODE_UNSCHEDULED, MODE_PLAYING, MODE_STOP_SCHEDULED: begin
            if (stop_in) begin
              nxt.mode         = MODE_STOP_SCHEDULED;
              res.active_count = stop_off[COUNT_W-1:0];
            end else if (stop_lt) begin
              nxt.mode  = MODE_FINISHED;
              res.ended = notify;
            end else if (cur.mode != MODE_UNSCHEDULED) begin
              res.active_count = n;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    res.play_state = nxt.mode;
  end

endmodule
`default_nettype wire

// ===== design/scheduled_source_gate_unit.sv =====
// An input transfer is held in the input register, and its result in the result register, before it reaches the output.
// Throughput: one item per cycle while the output is not stalled; input register, decision logic, result register.
// The play state is updated as an item moves into the result register, so
// each item sees the effect of the one before it.
// Reset (rst, synchronous): empty pipeline, unscheduled, no stop set,
// ended notification disabled.
`default_nettype none
module scheduled_source_gate_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,     // ended_notify_enable
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // frame_value[47:0], first_frame[95:48], frames_count[108:96], zero pad
  input  logic [ssg_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [ssg_pkg::CMD_W-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // start_offset[12:0], active_count[25:13], ended[26], play_state[29:27], zero pad
  output logic [ssg_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import ssg_pkg::*;

  logic        in_valid;
  item_t       in_item;
  logic        out_valid;
  res_t        out_res;
  gate_state_t gate;
  logic        notify;

  gate_state_t gate_next;
  res_t        res_next;
  logic        advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  ssg_core u_core (
    .item   (in_item),
    .cur    (gate),
    .notify (notify),
    .nxt    (gate_next),
    .res    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      out_valid       <= 1'b0;
      gate.mode       <= MODE_UNSCHEDULED;
      gate.stop_valid <= 1'b0;
      notify          <= 1'b0;
    end else begin
      if (cfg_we) begin
        notify <= cfg_wdata;
      end
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        gate      <= gate_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.cmd          <= cmd_t'(s_axis_tuser);
      in_item.frame_value  <= s_axis_tdata[FRAME_W-1:0];
      in_item.first_frame  <= s_axis_tdata[2*FRAME_W-1:FRAME_W];
      in_item.frames_count <= s_axis_tdata[2*FRAME_W+COUNT_W-1:2*FRAME_W];
    end
    if (advance) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_TDATA_W-2*COUNT_W-1-STATE_W){1'b0}},
                          out_res.play_state, out_res.ended,
                          out_res.active_count, out_res.start_offset};

endmodule
`default_nettype wire

// ===== design/ssg_checker.sv =====
// Port-level checks for the scheduled source gate, bound to the top level.
`default_nettype none
module ssg_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ssg_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import ssg_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transfer changed");

  a_ended_finished: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[26] |-> m_axis_tdata[29:27] == MODE_FINISHED)
    else $error("ended pulse outside finished state");

  a_fits_quantum: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ({1'b0, m_axis_tdata[12:0]} + {1'b0, m_axis_tdata[25:13]}) <= {1'b0, MAX_QUANTUM})
    else $error("offset plus audible count exceeds quantum");

endmodule

bind scheduled_source_gate_unit ssg_checker u_ssg_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
